// ===== sv/mtbd_pkg.sv =====
// Shared constants, types and word functions of the bounded-draw Mersenne Twister.
package mtbd_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int WORD_W       = 32;
    localparam int DIV_STEPS    = WORD_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int PADDR_W      = 3;

    localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd4357;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
    localparam logic [WORD_W-1:0] MATRIX_WORD  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] FAR_WRAP  = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_STEP  = ADDR_W'(TWIST_OFFSET);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Register index of the seed word on the configuration port
    localparam logic REG_SEED = 1'b0;

    // Controller states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FILL  = 8'b0000_0010,
        ST_RDA   = 8'b0000_0100,
        ST_RDB   = 8'b0000_1000,
        ST_RDC   = 8'b0001_0000,
        ST_TWIST = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } mtbd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;       // latch the bound of an accepted beat
        logic fill_init;  // start a seed refill at word zero
        logic fill_step;  // write one seeded word, advance
        logic rd_a;       // read word at pointer
        logic rd_b;       // read next word, hold first
        logic rd_c;       // read far word, hold second
        logic twist;      // write regenerated word, load divider
        logic div_step;   // one restoring-division step
        logic out_load;   // load the result register
    } mtbd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bound_zero;  // incoming bound is zero
        logic seeded;      // state array filled from current seed
        logic fill_last;   // last word of the refill
        logic div_last;    // last division step
        logic out_free;    // result register can take a new result
    } mtbd_sts_t;

    // Regenerate one word from current, next and far words
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ MATRIX_WORD;
        end
        return v;
    endfunction

    // Output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== sv/mtbd_ctrl.sv =====
// Controller state machine sequencing refill, word regeneration, division and output.
module mtbd_ctrl
    import mtbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mtbd_sts_t  sts,
    output mtbd_cmd_t  cmd
);

    mtbd_state_t state_reg;
    mtbd_state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (sts.bound_zero) begin
                        state_next = ST_OUT;
                    end else if (!sts.seeded) begin
                        cmd.fill_init = 1'b1;
                        state_next    = ST_FILL;
                    end else begin
                        state_next = ST_RDA;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                cmd.rd_a   = 1'b1;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_RDC;
            end
            ST_RDC: begin
                cmd.rd_c   = 1'b1;
                state_next = ST_TWIST;
            end
            ST_TWIST: begin
                cmd.twist  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mtbd_dp.sv =====
// Datapath: seed register, state memory, word regeneration, tempering, divider, result register.
module mtbd_dp
    import mtbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    // input payload
    input  logic [WORD_W-1:0]  s_bound_limit,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_draw_value,
    // control
    input  mtbd_cmd_t          cmd,
    output mtbd_sts_t          sts
);

    logic [WORD_W-1:0]    mem [STATE_WORDS];
    logic [WORD_W-1:0]    rdata_reg;
    logic [ADDR_W-1:0]    raddr;
    logic                 wen;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_W-1:0]    wdata;

    logic [WORD_W-1:0]    seed_reg;
    logic                 seeded_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [ADDR_W-1:0]    ptr_inc;
    logic [ADDR_W-1:0]    ptr_far;
    logic [ADDR_W-1:0]    fill_addr_reg;
    logic [WORD_W-1:0]    fill_word_reg;
    logic [WORD_W-1:0]    fill_word_next;
    logic [WORD_W-1:0]    bound_reg;
    logic [WORD_W-1:0]    word_a_reg;
    logic [WORD_W-1:0]    word_b_reg;
    logic [WORD_W-1:0]    new_word;
    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    rem_next;
    logic [WORD_W:0]      trial;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 m_valid_reg;
    logic [WORD_W-1:0]    m_draw_value_reg;
    logic                 seed_wr;

    // Configuration decode
    assign seed_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SEED);
    assign prdata  = (paddr[PADDR_W-1] == REG_SEED) ? seed_reg : '0;

    // Pointer neighbors with wrap
    assign ptr_inc = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + ADDR_W'(1);
    assign ptr_far = (ptr_reg >= FAR_WRAP) ? ptr_reg - FAR_WRAP : ptr_reg + FAR_STEP;

    // Read address select
    always_comb begin
        priority if (cmd.rd_b) begin
            raddr = ptr_inc;
        end else if (cmd.rd_c) begin
            raddr = ptr_far;
        end else begin
            raddr = ptr_reg;
        end
    end

    // Write port shared by refill and regeneration
    assign new_word = twist_word(word_a_reg, word_b_reg, rdata_reg);
    assign wen      = cmd.fill_step || cmd.twist;
    assign waddr    = cmd.fill_step ? fill_addr_reg : ptr_reg;
    assign wdata    = cmd.fill_step ? fill_word_reg : new_word;

    // State memory: read only in the three read steps, hold the far word for the twist
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_a || cmd.rd_b || cmd.rd_c) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Seed register and seeded flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= SEED_DEFAULT;
            seeded_reg <= 1'b0;
        end else begin
            if (seed_wr) begin
                seed_reg   <= pwdata;
                seeded_reg <= 1'b0;
            end else if (cmd.fill_step && (fill_addr_reg == LAST_ADDR)) begin
                seeded_reg <= 1'b1;
            end
        end
    end

    // Word pointer: reset by refill, advance on each regenerated word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.fill_init) begin
            ptr_reg <= '0;
        end else if (cmd.twist) begin
            ptr_reg <= ptr_inc;
        end
    end

    // Refill sequence: each word is the previous one times the multiplier
    assign fill_word_next = WORD_W'(fill_word_reg * SEED_MULT);

    always_ff @(posedge aclk) begin
        if (cmd.fill_init) begin
            fill_word_reg <= seed_reg;
            fill_addr_reg <= '0;
        end else if (cmd.fill_step) begin
            fill_word_reg <= fill_word_next;
            fill_addr_reg <= fill_addr_reg + ADDR_W'(1);
        end
    end

    // Capture bound and read words
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            bound_reg <= s_bound_limit;
        end
        if (cmd.rd_b) begin
            word_a_reg <= rdata_reg;
        end
        if (cmd.rd_c) begin
            word_b_reg <= rdata_reg;
        end
    end

    // Restoring division, one quotient bit per step
    assign trial    = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_next = (trial >= {1'b0, bound_reg}) ? WORD_W'(trial - {1'b0, bound_reg})
                                                   : trial[WORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.twist) begin
            dvd_reg     <= temper(new_word);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg     <= dvd_reg << 1;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Result register: drop the beat when taken, load a new result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_draw_value_reg <= (bound_reg == '0) ? '0 : rem_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_draw_value = m_draw_value_reg;

    // Status to controller
    assign sts.bound_zero = (s_bound_limit == '0);
    assign sts.seeded     = seeded_reg;
    assign sts.fill_last  = (fill_addr_reg == LAST_ADDR);
    assign sts.div_last   = (div_cnt_reg == DIV_LAST);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule

// ===== sv/mersenne_twister_bounded_draw.sv =====
// Top level of the bounded-draw Mersenne Twister: controller plus datapath.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_bound_limit[31:0]
//   m_        out        m_valid/m_ready    m_draw_value[31:0]
//   apb       in         psel/penable       paddr[2:0], pwdata/prdata (seed at 0x0)
//
// A draw goes from accept to result register through three memory reads on the
// single read port, a regenerate/temper step and 32 restoring-division steps.
// A zero bound skips reads and division. The first nonzero-bound draw after
// reset or a seed write refills all 624 words, one per cycle via the write port.
// Reset is synchronous on aresetn; no clearing pass. A stalled result waits in the
// output register; the next item is accepted once that result has been loaded.
module mersenne_twister_bounded_draw
    import mtbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [WORD_W-1:0]  s_bound_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_draw_value
);

    mtbd_cmd_t cmd;
    mtbd_sts_t sts;

    assign pready = 1'b1;

    // Sequencer
    mtbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath
    mtbd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_bound_limit (s_bound_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_draw_value  (m_draw_value),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== sv/mtbd_checker.sv =====
// Port-level checks of the bounded-draw block and their bind to the top level.
module mtbd_checker
    import mtbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [WORD_W-1:0] s_bound_limit,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [WORD_W-1:0] m_draw_value
);

    // Hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_draw_value))
        else $error("stalled result beat changed");

    // One item at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    // Zero bound into an empty output goes straight to the output state and gives zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_bound_limit == '0) && !m_valid
        |-> ##2 (m_valid && (m_draw_value == '0)))
        else $error("zero bound did not give a zero result");

endmodule

bind mersenne_twister_bounded_draw mtbd_checker u_mtbd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_bound_limit (s_bound_limit),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_draw_value  (m_draw_value)
);

// ===== sim/tb_top.sv =====
// Self-checking bench for the bounded-draw Mersenne Twister: seeds, bounds and flow control.
module tb_top;
    import mtbd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 60;
    localparam int IDLE_PCT    = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 100;
    localparam int UNUSED_REG  = 1;
    localparam logic [PADDR_W-1:0] SEED_ADDR   = PADDR_W'(REG_SEED) << 2;
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(UNUSED_REG * 4);

    localparam logic [WORD_W-1:0] CORNER_BOUNDS [18] = '{
        32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000,
        32'h7fff_ffff, 32'h0000_0002, 32'h0000_0003, 32'h0000_0000,
        32'hffff_fffe, 32'h0000_000a, 32'h0000_03e8, 32'h5555_5555,
        32'haaaa_aaaa, 32'h0001_0000, 32'hffff_0000, 32'h0000_0000,
        32'h0000_0007, 32'hffff_ffff
    };

    // Tracks generator state and the draws still owed by the block
    class mt_draw_tracker;
        logic [WORD_W-1:0] seed_word;
        logic [WORD_W-1:0] twist_store [STATE_WORDS];
        int unsigned       next_word;
        logic [WORD_W-1:0] pending_draws [$];

        function new();
            seed_word = SEED_DEFAULT;
            next_word = STATE_WORDS + 1;
            foreach (twist_store[i]) twist_store[i] = '0;
        endfunction

        // Only the seed register exists; anything else is dropped
        function void write_reg(int unsigned index, logic [WORD_W-1:0] value);
            if (index == REG_SEED) begin
                seed_word = value;
                next_word = STATE_WORDS + 1;
            end
        endfunction

        function void seed_fill();
            twist_store[0] = seed_word;
            for (int i = 1; i < STATE_WORDS; i++) begin
                twist_store[i] = twist_store[i-1] * 32'd69069;
            end
        endfunction

        // Regenerate in place; the last word sees the already updated word zero
        function void twist_all();
            logic [WORD_W-1:0] mix;
            logic [WORD_W-1:0] word;
            for (int k = 0; k < STATE_WORDS; k++) begin
                mix = {twist_store[k][31], twist_store[(k + 1) % STATE_WORDS][30:0]};
                word = twist_store[(k + TWIST_OFFSET) % STATE_WORDS] ^ (mix >> 1);
                if (mix[0]) begin
                    word = word ^ 32'h9908_b0df;
                end
                twist_store[k] = word;
            end
            next_word = 0;
        endfunction

        function logic [WORD_W-1:0] shape_output(logic [WORD_W-1:0] raw);
            logic [WORD_W-1:0] t;
            t = raw;
            t = t ^ (t >> 11);
            t = t ^ ((t << 7) & 32'h9d2c_5680);
            t = t ^ ((t << 15) & 32'hefc6_0000);
            t = t ^ (t >> 18);
            return t;
        endfunction

        // Note an accepted bound and queue the draw it must produce
        function void note_bound(logic [WORD_W-1:0] bound);
            logic [WORD_W-1:0] t;
            if (bound == '0) begin
                pending_draws.push_back('0);
                return;
            end
            if (next_word >= STATE_WORDS) begin
                if (next_word == STATE_WORDS + 1) begin
                    seed_fill();
                end
                twist_all();
            end
            t = shape_output(twist_store[next_word]);
            next_word++;
            pending_draws.push_back(t % bound);
        endfunction

        // Compare a result beat with the oldest owed draw
        function bit match_draw(logic [WORD_W-1:0] got, output logic [WORD_W-1:0] want);
            want = pending_draws.pop_front();
            return got === want;
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [WORD_W-1:0]  pwdata;
    logic [WORD_W-1:0]  prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [WORD_W-1:0]  s_bound_limit;
    logic               m_valid;
    logic               m_ready;
    logic [WORD_W-1:0]  m_draw_value;

    mt_draw_tracker tracker;
    int mismatches;
    int cycle_count;
    int bounds_sent;
    int draws_seen;

    mersenne_twister_bounded_draw dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bound_limit (s_bound_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_draw_value  (m_draw_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatches++;
    endtask

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Some zero and small bounds, powers of two, bounds near the top, mostly full range
    function automatic logic [WORD_W-1:0] pick_bound();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            return '0;
        end else if (roll < 30) begin
            return WORD_W'($urandom_range(1, 16));
        end else if (roll < 45) begin
            return 32'h1 << $urandom_range(0, 31);
        end else if (roll < 55) begin
            return 32'hffff_ffff - WORD_W'($urandom_range(0, 15));
        end
        return $urandom();
    endfunction

    // Offer one bound beat, idling first unless in the steady window
    task send_bound(input logic [WORD_W-1:0] bound);
        int gap;
        gap = 0;
        if (bounds_sent < 150 || bounds_sent >= 350) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_bound_limit <= bound;
        do @(posedge aclk); while (!s_ready);
        tracker.note_bound(bound);
        bounds_sent++;
    endtask

    // Drop valid and wait until every owed draw has come back
    task drain_draws();
        s_valid <= 1'b0;
        while (tracker.pending_draws.size() != 0) @(posedge aclk);
    endtask

    task apb_write(input logic [PADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(addr >> 2, data);
    endtask

    task run_phase(input int count);
        send_bound('0);
        repeat (count - 1) send_bound(pick_bound());
        drain_draws();
    endtask

    // Result side: check each beat, then choose the next ready
    initial begin
        int hold_left;
        bit held_once;
        logic [WORD_W-1:0] want;
        hold_left = 0;
        held_once = 1'b0;
        m_ready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                draws_seen++;
                if (tracker.pending_draws.size() == 0) begin
                    report_mismatch($sformatf("draw %0d with nothing outstanding", m_draw_value));
                end else if (!tracker.match_draw(m_draw_value, want)) begin
                    report_mismatch($sformatf("draw_value %0d, want %0d", m_draw_value, want));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && draws_seen >= 60) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (draws_seen >= 150 && draws_seen < 350) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus
    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_bound_limit = '0;
        mismatches    = 0;
        cycle_count   = 0;
        bounds_sent   = 0;
        draws_seen    = 0;
        tracker       = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Power-up seed: corners first, then enough draws to wrap the state array
        foreach (CORNER_BOUNDS[i]) send_bound(CORNER_BOUNDS[i]);
        repeat (680) send_bound(pick_bound());
        drain_draws();

        // Back-to-back seed writes, the later one wins; unmapped register is ignored
        apb_write(SEED_ADDR, $urandom());
        apb_write(UNUSED_ADDR, $urandom());
        apb_write(SEED_ADDR, 32'hffff_ffff);
        run_phase(25);

        apb_write(SEED_ADDR, 32'h0000_0000);
        run_phase(25);

        apb_write(SEED_ADDR, 32'h0000_0001);
        run_phase(25);

        apb_write(SEED_ADDR, $urandom());
        run_phase(25);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
